@@ design/vsht_pkg.sv @@
// shared types, constants and reset table for the vertex transform block
package vsht_pkg;

  localparam int VertexCount = 6;
  localparam int FracBits    = 16;
  localparam int TrigFrac    = 16;
  localparam int SlotW       = 3;
  localparam int AddrW       = $clog2(VertexCount * 4);
  localparam int StoreDepth  = VertexCount * 4;

  typedef enum logic [2:0] {
    CMD_LOAD    = 3'd0,
    CMD_MOVE_X  = 3'd1,
    CMD_MOVE_Z  = 3'd2,
    CMD_SCALE_Y = 3'd3,
    CMD_ROT_X   = 3'd4,
    CMD_MIRROR  = 3'd5,
    CMD_FLAT_Z  = 3'd6,
    CMD_PROJECT = 3'd7
  } cmd_e;

  localparam logic [1:0] RegFocal = 2'd0;
  localparam logic [1:0] RegCos   = 2'd1;
  localparam logic [1:0] RegSin   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_RD, ST_RDW, ST_CALC, ST_MUL2, ST_KDIV, ST_DIVX, ST_DIVY,
    ST_WR, ST_EMIT
  } state_e;

  // divider handshake between sequencer and divider
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // reset prism coordinate, component c of vertex i
  function automatic logic signed [31:0] prism_word(input int i, input int c);
    int t [6][3];
    t = '{'{150, 200, 360}, '{450, 200, 430}, '{200, 200, 70},
          '{210, 100, 320}, '{230, 100, 120}, '{330, 100, 350}};
    if (c == 3) return sat32(66'sd1 <<< FracBits);
    if (i >= 6) return '0;
    return sat32(66'(t[i][c]) <<< FracBits);
  endfunction

endpackage

@@ design/vsht_ram.sv @@
// generic single-port ram with registered read
module vsht_ram #(
  parameter int Width = 32,
  parameter int Depth = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

@@ design/vsht_div.sv @@
// radix-2 signed divider: sat32(a * 2^shift / b) truncating toward zero
module vsht_div import vsht_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               frac_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               busy_o,
  output logic               done_o,
  output logic signed [31:0] q_o
);
  localparam int NumW = 32 + FracBits;

  logic [NumW-1:0] num_q, num_d;
  logic [32:0]     rem_q, rem_d;
  logic [31:0]     den_q, den_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [6:0]      cnt_q, cnt_d;
  logic            neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [32:0]     trial;
  logic [NumW:0]   sq;
  logic [31:0]     ua, ub;
  logic signed [65:0] res;

  assign ua = a_i[31] ? 32'(-a_i) : 32'(a_i);
  assign ub = b_i[31] ? 32'(-b_i) : 32'(b_i);
  assign trial = {rem_q[31:0], num_q[NumW-1]} - {1'b0, den_q};

  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q; quo_d = quo_q;
    cnt_d = cnt_q; neg_d = neg_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      num_d  = frac_i ? {ua, FracBits'(0)} : NumW'(ua);
      den_d  = ub; rem_d = '0; quo_d = '0;
      cnt_d  = 7'(NumW); neg_d = a_i[31] ^ b_i[31]; busy_d = 1'b1;
    end else if (busy_q) begin
      // one quotient bit a cycle
      if (!trial[32]) begin
        rem_d = trial; quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], num_q[NumW-1]}; quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      num_d = {num_q[NumW-2:0], 1'b0};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  assign sq  = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
  assign res = 66'(signed'(sq));
  assign q_o = sat32(res);
  assign busy_o = busy_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; quo_q <= quo_d; neg_q <= neg_d;
  end
endmodule

@@ design/vertex_store_homogeneous_transform.sv @@
// top level: vertex store sequencer with ram, multiplier and divider
// a load holds the input while its four words are written; a transform or a projection
// walks every vertex: four reads, up to four multiplies and two or three divisions
// on the shared radix-2 divider; a projection also waits on output stalls
// throughput: one command at a time; projection beats leave one per vertex
// reset: state and configuration registers take their defaults, then an init pass writes the prism
module vertex_store_homogeneous_transform import vsht_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         command_i,
  input  logic [2:0]         vertex_slot_i,
  input  logic signed [31:0] operand_i,
  input  logic signed [31:0] load_x_i,
  input  logic signed [31:0] load_y_i,
  input  logic signed [31:0] load_z_i,
  input  logic signed [31:0] load_w_i,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [17:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_slot_o,
  output logic signed [31:0] proj_x_o,
  output logic signed [31:0] proj_y_o,
  output logic               divide_fault_o,
  output logic               last_vertex_o
);
  state_e st_q, st_d;
  logic [15:0] focal_q;
  logic signed [17:0] cos_q, sin_q;
  logic [2:0]  cmd_q;
  logic [SlotW-1:0] slot_q;
  logic signed [31:0] op_q, lx_q, ly_q, lz_q, lw_q;
  logic [SlotW-1:0] vi_q, vi_d;
  logic [2:0]  ci_q, ci_d;
  logic signed [31:0] v_q [4];
  logic signed [31:0] wp_q;
  logic signed [65:0] acc_q;
  logic [AddrW-1:0] ini_q;
  logic we;
  logic [AddrW-1:0] addr;
  logic [31:0] wdata, rdata;
  div_ctl_t dctl;
  logic frac;
  logic signed [31:0] da, db, dq;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q <= 16'd1000; cos_q <= 18'sd64729; sin_q <= 18'sd10252;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegFocal: focal_q <= cfg_data[15:0];
        RegCos:   cos_q <= cfg_data;
        RegSin:   sin_q <= cfg_data;
        default: ;
      endcase
    end
  end

  vsht_ram #(.Width(32), .Depth(StoreDepth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata));

  assign dctl.start = (st_q == ST_KDIV || st_q == ST_DIVX || st_q == ST_DIVY)
                      && !dctl.busy && !dctl.done && ci_q == 3'd0;
  vsht_div u_div (.clk_i, .rst_ni, .start_i(dctl.start), .frac_i(frac), .a_i(da),
    .b_i(db), .busy_o(dctl.busy), .done_o(dctl.done), .q_o(dq));

  // divider operand selection
  always_comb begin
    frac = st_q != ST_KDIV;
    da = (st_q == ST_KDIV) ? v_q[2] : (st_q == ST_DIVX ? v_q[0] : v_q[1]);
    db = (st_q == ST_KDIV) ? ((focal_q == 16'd0) ? 32'sd1 : 32'(focal_q))
         : (cmd_q == CMD_PROJECT ? wp_q : v_q[3]);
  end

  // multiplier operand selection, one product per step
  always_comb begin
    ma = v_q[1]; mb = op_q;
    unique case (cmd_q)
      CMD_MOVE_X, CMD_MOVE_Z: begin ma = op_q; mb = v_q[3]; end
      CMD_ROT_X: begin
        ma = (st_q == ST_CALC || (st_q == ST_MUL2 && ci_q == 3'd2)) ? v_q[1] : v_q[2];
        mb = 32'(ci_q[0] ? sin_q : cos_q);
        if (st_q == ST_MUL2) mb = 32'(ci_q[0] ? cos_q : sin_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) prod_q <= 64'(ma) * 64'(mb);

  assign in_stall  = st_q != ST_IDLE;
  assign out_valid = st_q == ST_EMIT;

  // next state
  always_comb begin
    st_d = st_q; vi_d = vi_q; ci_d = ci_q;
    unique case (st_q)
      ST_IDLE: if (in_valid) begin
        st_d = ST_RD; vi_d = '0; ci_d = '0;
        if (command_i == CMD_LOAD)
          st_d = (vertex_slot_i < SlotW'(VertexCount)) ? ST_WR : ST_IDLE;
      end
      ST_INIT: if (ini_q == AddrW'(StoreDepth - 1)) st_d = ST_IDLE;
      ST_RD:   begin st_d = ST_RDW; end
      ST_RDW:  begin
        ci_d = ci_q + 3'd1;
        st_d = (ci_q == 3'd3) ? ST_CALC : ST_RD;
        if (ci_q == 3'd3) ci_d = '0;
      end
      ST_CALC: begin
        ci_d = ci_q + 3'd1;
        if (ci_q == 3'd1) begin
          ci_d = '0;
          st_d = (cmd_q == CMD_ROT_X) ? ST_MUL2
               : (cmd_q == CMD_PROJECT ? ST_KDIV : ST_DIVX);
        end
      end
      ST_MUL2: begin
        ci_d = ci_q + 3'd1;
        if (ci_q == 3'd3) begin ci_d = '0; st_d = ST_DIVX; end
      end
      ST_KDIV: if (dctl.done) st_d = ST_DIVX;
      ST_DIVX: if (dctl.done) st_d = ST_DIVY;
      ST_DIVY: if (dctl.done) st_d = (cmd_q == CMD_PROJECT) ? ST_EMIT : ST_WR;
      ST_WR: begin
        ci_d = ci_q + 3'd1;
        if (ci_q == 3'd3) begin
          ci_d = '0; vi_d = vi_q + SlotW'(1);
          st_d = (cmd_q == CMD_LOAD || vi_q == SlotW'(VertexCount - 1)) ? ST_IDLE : ST_RD;
        end
      end
      ST_EMIT: if (!out_stall) begin
        vi_d = vi_q + SlotW'(1);
        st_d = (vi_q == SlotW'(VertexCount - 1)) ? ST_IDLE : ST_RD;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // ram port
  always_comb begin
    we = 1'b0;
    addr = AddrW'({vi_q, 2'b00} + {3'b000, ci_q[1:0]});
    wdata = v_q[ci_q[1:0]];
    unique case (st_q)
      ST_INIT: begin
        we = 1'b1; addr = ini_q;
        wdata = prism_word(int'(ini_q) / 4, int'(ini_q) % 4);
      end
      ST_WR: begin
        we = 1'b1;
        if (cmd_q == CMD_LOAD) begin
          addr = AddrW'({slot_q, 2'b00} + {3'b000, ci_q[1:0]});
          unique case (ci_q[1:0])
            2'd0: wdata = lx_q;
            2'd1: wdata = ly_q;
            2'd2: wdata = lz_q;
            default: wdata = lw_q;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_INIT; ini_q <= '0; vi_q <= '0; ci_q <= '0;
    end else begin
      st_q <= st_d; vi_q <= vi_d; ci_q <= ci_d;
      if (st_q == ST_INIT) ini_q <= ini_q + AddrW'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_valid) begin
      cmd_q <= command_i; slot_q <= vertex_slot_i; op_q <= operand_i;
      lx_q <= load_x_i; ly_q <= load_y_i; lz_q <= load_z_i; lw_q <= load_w_i;
    end
    if (st_q == ST_RDW) v_q[ci_q[1:0]] <= rdata;
    // second calc step: product of first factor is ready
    if (st_q == ST_CALC && ci_q == 3'd1) begin
      unique case (cmd_q)
        CMD_MOVE_X: v_q[0] <= sat32((66'(v_q[0]) <<< FracBits) + 66'(prod_q) >>> FracBits);
        CMD_MOVE_Z: v_q[2] <= sat32((66'(v_q[2]) <<< FracBits) + 66'(prod_q) >>> FracBits);
        CMD_SCALE_Y: v_q[1] <= sat32(66'(prod_q) >>> FracBits);
        CMD_ROT_X: acc_q <= 66'(prod_q);
        CMD_MIRROR: v_q[0] <= sat32(-66'(v_q[0]));
        CMD_FLAT_Z: v_q[2] <= '0;
        default: ;
      endcase
    end
    // rotate: y*cos from calc, minus z*sin -> new y; then z*cos plus y*sin -> new z
    if (st_q == ST_MUL2) begin
      unique case (ci_q[1:0])
        2'd0: ;
        2'd1: acc_q <= acc_q - 66'(prod_q);
        2'd2: begin
          v_q[1] <= sat32(acc_q >>> TrigFrac);
          acc_q <= 66'(prod_q);
        end
        default: v_q[2] <= sat32(acc_q + 66'(prod_q) >>> TrigFrac);
      endcase
    end
    if (st_q == ST_KDIV && dctl.done) wp_q <= sat32(66'(dq) + 66'(v_q[3]));
    if (st_q == ST_DIVX && dctl.done) v_q[0] <= (db == 0) ? '0 : dq;
    if (st_q == ST_DIVY && dctl.done) v_q[1] <= (db == 0) ? '0 : dq;
  end

  assign out_slot_o     = vi_q;
  assign proj_x_o       = v_q[0];
  assign proj_y_o       = v_q[1];
  assign divide_fault_o = wp_q == 32'sd0;
  assign last_vertex_o  = vi_q == SlotW'(VertexCount - 1);
endmodule

@@ design/vsht_checker.sv @@
// port-level checker for the vertex transform block, bound to the top level
module vsht_checker import vsht_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic last_vertex_o,
  input logic [2:0] out_slot_o
);
  // no input beat while results are shown
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid |-> in_stall)
    else $error("input taken during output");
  // stalled beat holds its slot
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_slot_o)) else $error("slot moved");
  // last flag only on the final slot
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (last_vertex_o == (out_slot_o == 3'(VertexCount - 1))))
    else $error("last flag wrong");
  // slot in range
  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_slot_o < 3'(VertexCount)) else $error("slot range");
endmodule

bind vertex_store_homogeneous_transform vsht_checker u_chk (.*);

@@ verif/tb.sv @@
// regression bench for the homogeneous vertex transform block
module tb;
  import vsht_pkg::*;

  localparam int  WatchLimit = 40000;
  localparam int  SettleWait = 1500;
  localparam int  RandItems  = 260;
  localparam logic signed [31:0] One = 32'sh0001_0000;

  typedef struct packed {
    logic [2:0]         slot;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               fault;
    logic               last;
  } proj_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] command_i = '0;
  logic [2:0] vertex_slot_i = '0;
  logic signed [31:0] operand_i = '0;
  logic signed [31:0] load_x_i = '0, load_y_i = '0, load_z_i = '0, load_w_i = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [17:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_slot_o;
  logic signed [31:0] proj_x_o, proj_y_o;
  logic divide_fault_o, last_vertex_o;

  // predictor state
  logic signed [31:0] verts [VertexCount][4];
  logic [15:0]        focal_k;
  logic signed [17:0] cos_q, sin_q;
  proj_beat_t         pending_beats [$];

  bit failed = 1'b0;
  bit quiet = 1'b0;
  int idle_cycles = 0;
  int stall_left = 0;

  vertex_store_homogeneous_transform u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // fixed-point divide, truncating toward zero, zero divisor gives zero
  function automatic logic signed [31:0] qdiv(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    if (b == 0) return '0;
    return clamp32((longint'(a) <<< FracBits) / longint'(b));
  endfunction

  // update the vertex model for one accepted command
  task automatic apply_command(input cmd_e cmd, input logic [2:0] slot,
                               input logic signed [31:0] op,
                               input logic signed [31:0] lx, ly, lz, lw);
    longint y, z, k, wp;
    proj_beat_t b;
    if (cmd == CMD_LOAD) begin
      if (slot < VertexCount) begin
        verts[slot][0] = lx; verts[slot][1] = ly;
        verts[slot][2] = lz; verts[slot][3] = lw;
      end
    end else if (cmd == CMD_PROJECT) begin
      k = (focal_k == 0) ? 1 : longint'(focal_k);
      for (int i = 0; i < VertexCount; i++) begin
        wp = clamp32(longint'(verts[i][2]) / k + longint'(verts[i][3]));
        b.slot  = 3'(i);
        b.px    = qdiv(verts[i][0], wp[31:0]);
        b.py    = qdiv(verts[i][1], wp[31:0]);
        b.fault = (wp == 0);
        b.last  = (i == VertexCount - 1);
        pending_beats.push_back(b);
      end
    end else begin
      for (int i = 0; i < VertexCount; i++) begin
        y = verts[i][1];
        z = verts[i][2];
        case (cmd)
          CMD_MOVE_X: verts[i][0] = clamp32(((longint'(verts[i][0]) <<< FracBits)
                                   + longint'(op) * longint'(verts[i][3])) >>> FracBits);
          CMD_MOVE_Z: verts[i][2] = clamp32(((longint'(verts[i][2]) <<< FracBits)
                                   + longint'(op) * longint'(verts[i][3])) >>> FracBits);
          CMD_SCALE_Y: verts[i][1] = clamp32((y * longint'(op)) >>> FracBits);
          CMD_ROT_X: begin
            verts[i][1] = clamp32((y * longint'(cos_q) - z * longint'(sin_q)) >>> TrigFrac);
            verts[i][2] = clamp32((y * longint'(sin_q) + z * longint'(cos_q)) >>> TrigFrac);
          end
          CMD_MIRROR: verts[i][0] = clamp32(-longint'(verts[i][0]));
          default:    verts[i][2] = '0;
        endcase
        verts[i][0] = qdiv(verts[i][0], verts[i][3]);
        verts[i][1] = qdiv(verts[i][1], verts[i][3]);
      end
    end
  endtask

  // drive one command beat and wait for it to be taken
  task automatic send_cmd(input cmd_e cmd, input logic [2:0] slot,
                          input logic signed [31:0] op,
                          input logic signed [31:0] lx, ly, lz, lw);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    command_i     <= cmd;
    vertex_slot_i <= slot;
    operand_i     <= op;
    load_x_i <= lx; load_y_i <= ly; load_z_i <= lz; load_w_i <= lw;
    do @(posedge clk_i); while (in_stall);
    apply_command(cmd, slot, op, lx, ly, lz, lw);
  endtask

  task automatic send_op(input cmd_e cmd, input logic signed [31:0] op);
    send_cmd(cmd, 3'd0, op, $urandom, $urandom, $urandom, $urandom);
  endtask

  // release the input, then wait until no beats are pending and the block has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [17:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      RegFocal: focal_k = val[15:0];
      RegCos:   cos_q   = val;
      default:  sin_q   = val;
    endcase
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return (32'($urandom_range(0, 2000)) - 32'sd1000) * One
                      + 32'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic signed [31:0] rand_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return $urandom;
      2:       return -One;
      default: return 32'($urandom_range(1, 8)) * One + 32'($urandom_range(0, 4095));
    endcase
  endfunction

  // reset contents: project the built-in prism
  task automatic test_reset_prism();
    send_op(CMD_PROJECT, '0);
    drain();
  endtask

  // every command, field extremes and the special cases
  task automatic test_directed();
    send_cmd(CMD_LOAD, 3'd0, '0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, One);
    send_cmd(CMD_LOAD, 3'd1, '0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, One);
    send_cmd(CMD_LOAD, 3'd5, '0, 10 * One, 20 * One, 30 * One, '0);
    send_cmd(CMD_LOAD, 3'd6, '0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_cmd(CMD_LOAD, 3'd7, '0, '0, '0, '0, '0);
    send_op(CMD_PROJECT, '0);
    send_op(CMD_MIRROR, '0);
    send_op(CMD_PROJECT, '0);
    send_op(CMD_MOVE_X, 32'sh7fffffff);
    send_op(CMD_MOVE_Z, 32'sh80000000);
    send_op(CMD_PROJECT, '0);
    send_cmd(CMD_LOAD, 3'd2, '0, 5 * One, -7 * One, -1000 * One, One);
    send_cmd(CMD_LOAD, 3'd3, '0, 3 * One, 4 * One, 2000 * One, 2 * One);
    send_op(CMD_SCALE_Y, -3 * One);
    send_op(CMD_SCALE_Y, 32'sh7fffffff);
    send_op(CMD_ROT_X, '0);
    send_op(CMD_PROJECT, '0);
    send_op(CMD_FLAT_Z, '0);
    send_op(CMD_PROJECT, '0);
    drain();
  endtask

  // register extremes, including a zero focal distance
  task automatic test_config_extremes();
    write_reg(RegFocal, 18'd0);
    write_reg(RegCos, 18'sd65536);
    write_reg(RegSin, -18'sd65536);
    for (int i = 0; i < VertexCount; i++)
      send_cmd(CMD_LOAD, 3'(i), '0, rand_coord(), rand_coord(),
               -32'(i) * One, rand_weight());
    send_op(CMD_ROT_X, '0);
    send_op(CMD_PROJECT, '0);
    drain();
    write_reg(RegFocal, 18'd65535);
    write_reg(RegCos, -18'sd65536);
    write_reg(RegSin, 18'sd65536);
    send_op(CMD_ROT_X, '0);
    send_op(CMD_PROJECT, '0);
    drain();
    write_reg(RegFocal, 18'd1);
    send_op(CMD_PROJECT, '0);
    drain();
  endtask

  // random vertex sets with random transform chains, registers changed per phase
  task automatic test_random();
    cmd_e cmd;
    for (int n = 0; n < RandItems; n++) begin
      if (n % 65 == 64) begin
        drain();
        write_reg(RegFocal, 18'($urandom_range(0, 65535)));
        write_reg(RegCos, 18'($urandom_range(0, 131072)) - 18'sd65536);
        write_reg(RegSin, 18'($urandom_range(0, 131072)) - 18'sd65536);
      end
      if (n == RandItems - 40) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2: send_cmd(CMD_LOAD, 3'($urandom_range(0, 7)), $urandom,
                          rand_coord(), rand_coord(), rand_coord(), rand_weight());
        3, 4:    send_op(CMD_PROJECT, $urandom);
        default: begin
          cmd = cmd_e'($urandom_range(1, 6));
          send_op(cmd, ($urandom_range(0, 2) == 0) ? $urandom
                       : (32'($urandom_range(0, 8)) - 32'sd4) * One
                         + 32'($urandom_range(0, 65535)));
        end
      endcase
    end
    in_valid <= 1'b0;
  endtask

  // receiver stall bursts
  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each projected beat with the oldest expectation
  always @(posedge clk_i) begin
    proj_beat_t got, want;
    if (rst_ni && out_valid && !out_stall) begin
      got = '{out_slot_o, proj_x_o, proj_y_o, divide_fault_o, last_vertex_o};
      if (pending_beats.size() == 0) begin
        $display("%0t unexpected beat: slot %0d x %h y %h fault %b last %b", $time,
                 got.slot, got.px, got.py, got.fault, got.last);
        failed = 1'b1;
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected slot %0d x %h y %h fault %b last %b", $time,
                   want.slot, want.px, want.py, want.fault, want.last);
          $display("%0t           actual   slot %0d x %h y %h fault %b last %b", $time,
                   got.slot, got.px, got.py, got.fault, got.last);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("vertex_store_homogeneous_transform regression: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < VertexCount; i++)
      for (int c = 0; c < 4; c++) verts[i][c] = prism_word(i, c);
    focal_k = 16'd1000;
    cos_q   = 18'sd64729;
    sin_q   = 18'sd10252;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_prism();
    test_directed();
    test_config_extremes();
    test_random();
    drain();
    if (!failed && pending_beats.size() == 0) begin
      $display("vertex_store_homogeneous_transform regression: pass");
    end else begin
      $display("vertex_store_homogeneous_transform regression: fail");
    end
    $finish;
  end

endmodule
